// ----- rtl/core/assert_macros.svh -----
// Shared assertion macros for the RTL checkers.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, skipped while reset is high.
`define RBS_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define RBS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/core/rbs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbs_pkg
// Shared types and constants for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
package rbs_pkg;

   // Default number of fraction bits of the fixed-point coordinates
   localparam int FRAC_BITS_DEF = 16;

   // Coordinate and register widths
   localparam int COORD_W  = 32;
   localparam int THRESH_W = 17;
   localparam int DIST_W   = 31;

   // Reset value of the parallel threshold
   localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(1);

   // Input word: one ray and one box
   typedef struct packed {
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
      logic signed [COORD_W-1:0] origin_z;
      logic signed [COORD_W-1:0] dir_x;
      logic signed [COORD_W-1:0] dir_y;
      logic signed [COORD_W-1:0] dir_z;
      logic signed [COORD_W-1:0] box_min_x;
      logic signed [COORD_W-1:0] box_min_y;
      logic signed [COORD_W-1:0] box_min_z;
      logic signed [COORD_W-1:0] box_max_x;
      logic signed [COORD_W-1:0] box_max_y;
      logic signed [COORD_W-1:0] box_max_z;
   } req_payload_type;

   // Result word
   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] entry_distance;
   } rsp_payload_type;

endpackage

// ----- rtl/core/ray_box_slab_intersect.sv -----
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Pipelined ray versus axis-aligned box test with saturated entry distance.
// ----------------------------------------------------------------------------
// Takes one ray/box word per cycle while the output side is ready and
// returns one result word per input word, in order.
// The six slab dividers run side by side as a restoring divider with one
// quotient bit per pipeline stage (31 stages plus an overflow check),
// preceded by a front stage and followed by two reduction stages.
// Every stage advances on its own when the stage ahead is empty or moving,
// so bubbles close up and the input keeps flowing while a result waits at
// the output register, until the pipeline fills. The user must write the
// parallel threshold through csr_ only while the pipeline is empty; the
// block itself does not enforce it.
module ray_box_slab_intersect #(
   parameter int FRAC_BITS = rbs_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  rbs_pkg::req_payload_type      req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output rbs_pkg::rsp_payload_type      rsp_payload,
   input  logic                          csr_write_enable,
   input  logic [rbs_pkg::THRESH_W-1:0]  csr_write_data
);
   import rbs_pkg::*;

   localparam int NUM_W  = COORD_W + 1 + FRAC_BITS;  // shifted numerator magnitude
   localparam int QBITS  = COORD_W - 1;              // quotient bits below overflow
   localparam int CMP_W  = COORD_W + QBITS;          // widest shifted divisor
   localparam int NSTAGE = QBITS + 4;                // front, ovf, div, sort, out
   localparam int SORT_S = QBITS + 2;
   localparam int OUT_S  = QBITS + 3;

   localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Divider record, one slot per slab (two per axis)
   typedef struct packed {
      logic [5:0][NUM_W-1:0]   rem;
      logic [5:0][QBITS-1:0]   quo;
      logic [5:0]              ovf;
      logic [5:0]              neg;
      logic [2:0][COORD_W-1:0] den;
      logic [2:0]              par;
      logic                    par_miss;
      logic                    dir_zero;
   } div_rec_type;

   // Sorted slab interval record
   typedef struct packed {
      logic [2:0][COORD_W-1:0] lo;
      logic [2:0][COORD_W-1:0] hi;
      logic [2:0]              par;
      logic                    par_miss;
      logic                    dir_zero;
   } sort_rec_type;

   logic [THRESH_W-1:0] thresh_ff;
   logic [NSTAGE-1:0]   valid_ff;
   logic [NSTAGE:0]     adv;
   div_rec_type         front_in;
   div_rec_type         div_ff [QBITS+2];
   div_rec_type         div_in [QBITS+2];
   sort_rec_type        sort_ff;
   sort_rec_type        sort_in;
   rsp_payload_type     out_ff;
   rsp_payload_type     out_in;

   // Hold the parallel threshold
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= THRESH_RESET;
      end else if (csr_write_enable) begin
         thresh_ff <= csr_write_data;
      end
   end

   // Advance a stage when it is empty or the stage ahead advances
   assign adv[NSTAGE] = rsp_ready;
   for (genvar s = 0; s < NSTAGE; s++) begin : g_adv
      assign adv[s] = !valid_ff[s] || adv[s+1];
   end
   assign req_ready = adv[0];

   // Move valid bits along with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NSTAGE; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // Front: slab numerators, divisor magnitudes, parallel checks
   always_comb begin
      logic signed [COORD_W-1:0] org  [3];
      logic signed [COORD_W-1:0] dir  [3];
      logic signed [COORD_W-1:0] bmin [3];
      logic signed [COORD_W-1:0] bmax [3];
      logic signed [COORD_W:0]   diff;
      logic [COORD_W:0]          dmag;
      logic [COORD_W-1:0]        dir_mag;
      org  = '{req_payload.origin_x, req_payload.origin_y, req_payload.origin_z};
      dir  = '{req_payload.dir_x, req_payload.dir_y, req_payload.dir_z};
      bmin = '{req_payload.box_min_x, req_payload.box_min_y, req_payload.box_min_z};
      bmax = '{req_payload.box_max_x, req_payload.box_max_y, req_payload.box_max_z};
      front_in = '0;
      front_in.dir_zero = (dir[0] == '0) && (dir[1] == '0) && (dir[2] == '0);
      for (int a = 0; a < 3; a++) begin
         dir_mag = dir[a][COORD_W-1] ? (~dir[a] + 1'b1) : dir[a];
         front_in.den[a] = dir_mag;
         front_in.par[a] = (dir[a] == '0) ||
                           (dir_mag < {{(COORD_W-THRESH_W){1'b0}}, thresh_ff});
         if (front_in.par[a] && ((org[a] < bmin[a]) || (org[a] > bmax[a]))) begin
            front_in.par_miss = 1'b1;
         end
         for (int b = 0; b < 2; b++) begin
            diff = (b == 0) ? ({bmin[a][COORD_W-1], bmin[a]} - {org[a][COORD_W-1], org[a]})
                            : ({bmax[a][COORD_W-1], bmax[a]} - {org[a][COORD_W-1], org[a]});
            dmag = diff[COORD_W] ? (~diff + 1'b1) : diff;
            front_in.neg[2*a+b] = diff[COORD_W] ^ dir[a][COORD_W-1];
            front_in.rem[2*a+b] = NUM_W'(dmag) << FRAC_BITS;
         end
      end
   end

   // Overflow check: quotient reaches 2^31 when num >> 31 >= den
   always_comb begin
      div_in[0] = front_in;
      div_in[1] = div_ff[0];
      for (int j = 0; j < 6; j++) begin
         div_in[1].ovf[j] = (div_ff[0].rem[j] >> QBITS) >= NUM_W'(div_ff[0].den[j/2]);
      end
   end

   // Restoring divide: one quotient bit per stage, most significant first
   for (genvar s = 0; s < QBITS; s++) begin : g_div
      localparam int BIT = QBITS - 1 - s;
      always_comb begin
         logic [CMP_W-1:0] sub;
         div_in[s+2] = div_ff[s+1];
         for (int j = 0; j < 6; j++) begin
            sub = CMP_W'(div_ff[s+1].den[j/2]) << BIT;
            if (CMP_W'(div_ff[s+1].rem[j]) >= sub) begin
               div_in[s+2].rem[j]      = NUM_W'(CMP_W'(div_ff[s+1].rem[j]) - sub);
               div_in[s+2].quo[j][BIT] = 1'b1;
            end
         end
      end
   end

   // Divider pipeline registers
   for (genvar s = 0; s < QBITS + 2; s++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (adv[s]) begin
            div_ff[s] <= div_in[s];
         end
      end
   end

   // Saturate, apply sign and order each slab pair
   always_comb begin
      logic signed [COORD_W-1:0] t [2];
      div_rec_type d;
      d = div_ff[QBITS+1];
      sort_in = '0;
      sort_in.par      = d.par;
      sort_in.par_miss = d.par_miss;
      sort_in.dir_zero = d.dir_zero;
      for (int a = 0; a < 3; a++) begin
         for (int b = 0; b < 2; b++) begin
            if (d.ovf[2*a+b]) begin
               t[b] = d.neg[2*a+b] ? T_MIN : T_MAX;
            end else if (d.neg[2*a+b]) begin
               t[b] = -$signed({1'b0, d.quo[2*a+b]});
            end else begin
               t[b] = $signed({1'b0, d.quo[2*a+b]});
            end
         end
         if (t[0] > t[1]) begin
            sort_in.lo[a] = t[1];
            sort_in.hi[a] = t[0];
         end else begin
            sort_in.lo[a] = t[0];
            sort_in.hi[a] = t[1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[SORT_S]) begin
         sort_ff <= sort_in;
      end
   end

   // Intersect the crossing slabs with [0, max] and decide the hit
   always_comb begin
      logic signed [COORD_W-1:0] tmin;
      logic signed [COORD_W-1:0] tmax;
      logic                      hit;
      tmin = '0;
      tmax = T_MAX;
      for (int a = 0; a < 3; a++) begin
         if (!sort_ff.par[a]) begin
            if ($signed(sort_ff.lo[a]) > tmin) begin
               tmin = sort_ff.lo[a];
            end
            if ($signed(sort_ff.hi[a]) < tmax) begin
               tmax = sort_ff.hi[a];
            end
         end
      end
      hit = !sort_ff.dir_zero && !sort_ff.par_miss && (tmin <= tmax);
      out_in.hit            = hit;
      out_in.entry_distance = hit ? tmin[DIST_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (adv[OUT_S]) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid   = valid_ff[OUT_S];
   assign rsp_payload = out_ff;

endmodule

// ----- rtl/core/rbs_checker.sv -----
// ----------------------------------------------------------------------------
// rbs_checker
// Port-level checks for the ray / box slab intersection block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rbs_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_ready,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input rbs_pkg::rsp_payload_type rsp_payload
);
   import rbs_pkg::*;

   // A stalled result word keeps its value
   `RBS_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "rsp word changed")

   // A miss carries zero distance
   `RBS_ASSERT(a_miss_zero, clock, reset, rsp_valid && !rsp_payload.hit |-> rsp_payload.entry_distance == '0, "miss distance")

   // An open output side never blocks the input
   `RBS_ASSERT(a_ready_flow, clock, reset, rsp_ready |-> req_ready, "input blocked while output is ready")

   // No result word right after reset
   `RBS_ASSERT_ALWAYS(a_reset_empty, clock, $past(reset) |-> !rsp_valid, "result word after reset")

endmodule

bind ray_box_slab_intersect rbs_checker u_rbs_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload)
);

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the ray / box slab intersection block. Words are
// driven over valid/ready with random idling on both sides. Each accepted
// word is predicted in fixed point and the result words are compared in order.
// ----------------------------------------------------------------------------
module tb_top;
   import rbs_pkg::*;

   localparam int LATENCY   = 40;
   localparam int CYCLE_MAX = 400000;

   typedef struct packed {
      logic              hit;
      logic [DIST_W-1:0] entry_distance;
   } slab_result_type;

   // Slab-clipping predictor and queue of expected result words
   class slab_scoreboard;
      slab_result_type  pending[$];
      logic [THRESH_W-1:0] thresh;
      int               errors;

      // Print one mismatch line and count it
      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $time, msg);
         errors++;
      endtask

      function longint clip_param(longint num, longint den);
         longint unsigned q, mn, md;
         mn = (num < 0) ? -num : num;
         md = (den < 0) ? -den : den;
         q  = (mn << 16) / md;
         if ((num < 0) != (den < 0)) begin
            if (q >= 64'h8000_0000) return -64'sd2147483648;
            return -longint'(q);
         end
         if (q > 64'h7FFF_FFFF) return 64'sd2147483647;
         return longint'(q);
      endfunction

      function void note_ray(req_payload_type p);
         longint org[3], dir[3], lo[3], hi[3];
         longint tn, tx, t1, t2, s, md;
         slab_result_type r;
         bit hit;
         org = '{longint'(p.origin_x), longint'(p.origin_y), longint'(p.origin_z)};
         dir = '{longint'(p.dir_x), longint'(p.dir_y), longint'(p.dir_z)};
         lo  = '{longint'(p.box_min_x), longint'(p.box_min_y), longint'(p.box_min_z)};
         hi  = '{longint'(p.box_max_x), longint'(p.box_max_y), longint'(p.box_max_z)};
         tn = 0;
         tx = 64'sd2147483647;
         hit = !(dir[0] == 0 && dir[1] == 0 && dir[2] == 0);
         for (int a = 0; a < 3 && hit; a++) begin
            md = (dir[a] < 0) ? -dir[a] : dir[a];
            if (dir[a] == 0 || md < longint'(thresh)) begin
               if (org[a] < lo[a] || org[a] > hi[a]) hit = 0;
            end else begin
               t1 = clip_param(lo[a] - org[a], dir[a]);
               t2 = clip_param(hi[a] - org[a], dir[a]);
               if (t1 > t2) begin
                  s = t1; t1 = t2; t2 = s;
               end
               if (t1 > tn) tn = t1;
               if (t2 < tx) tx = t2;
               if (tn > tx) hit = 0;
            end
         end
         r.hit = hit;
         r.entry_distance = hit ? tn[DIST_W-1:0] : '0;
         pending = {pending, r};
      endfunction

      task check_result(rsp_payload_type got);
         slab_result_type w;
         if (pending.size() == 0) begin
            report_mismatch("result word with nothing expected");
            return;
         end
         w = pending.pop_front();
         if (got.hit !== w.hit)
            report_mismatch($sformatf("hit %0b, expected %0b", got.hit, w.hit));
         if (got.entry_distance !== w.entry_distance)
            report_mismatch($sformatf("entry_distance %h, expected %h",
                                      got.entry_distance, w.entry_distance));
      endtask
   endclass

   logic                clock = 0;
   logic                reset = 1;
   logic                req_valid = 0;
   logic                req_ready;
   req_payload_type     req_payload = '0;
   logic                rsp_valid;
   logic                rsp_ready = 0;
   rsp_payload_type     rsp_payload;
   logic                csr_write_enable = 0;
   logic [THRESH_W-1:0] csr_write_data = '0;

   slab_scoreboard sb = new();
   int  cycle_count = 0;
   int  send_idle = 0;
   int  recv_stall = 0;

   always #10 clock = ~clock;

   ray_box_slab_intersect i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   // Check result words and run the receiver stall pattern
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset) begin
         if (rsp_valid && rsp_ready) sb.check_result(rsp_payload);
         rsp_ready <= ($urandom_range(99) >= recv_stall);
      end
      if (cycle_count > CYCLE_MAX) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Send one word, idling at random before it; valid stays high afterwards
   task automatic send_word(req_payload_type p);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid   <= 1;
      req_payload <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_ray(p);
   endtask

   // Drop valid, wait for the pipeline to drain, then write the threshold
   task automatic set_threshold(logic [THRESH_W-1:0] v);
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      csr_write_enable <= 1;
      csr_write_data   <= v;
      @(posedge clock);
      csr_write_enable <= 0;
      sb.thresh = v;
   endtask

   function automatic logic [31:0] rand_coord(int mode);
      case (mode)
         0: return $urandom();
         1: return 32'($signed($urandom_range(2000)) - 1000) << 16;
         2: return 32'($signed($urandom_range(200000)) - 100000);
         default: begin
            case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'h0;
               default: return $urandom_range(3);
            endcase
         end
      endcase
   endfunction

   // Build a random ray/box word, mostly well-formed boxes
   function automatic req_payload_type rand_ray();
      req_payload_type p;
      logic signed [31:0] a, b;
      int m;
      m = $urandom_range(9);
      m = (m < 2) ? 0 : (m < 6) ? 1 : (m < 9) ? 2 : 3;
      p.origin_x = rand_coord(m); p.origin_y = rand_coord(m); p.origin_z = rand_coord(m);
      p.dir_x = rand_coord(m); p.dir_y = rand_coord(m); p.dir_z = rand_coord(m);
      if ($urandom_range(5) == 0) p.dir_y = $urandom_range(3);
      for (int k = 0; k < 3; k++) begin
         a = rand_coord(m);
         b = rand_coord(m);
         if ($urandom_range(9) != 0 && a > b) begin
            a ^= b; b ^= a; a ^= b;
         end
         case (k)
            0: begin p.box_min_x = a; p.box_max_x = b; end
            1: begin p.box_min_y = a; p.box_max_y = b; end
            default: begin p.box_min_z = a; p.box_max_z = b; end
         endcase
      end
      return p;
   endfunction

   function automatic req_payload_type make_ray(logic [31:0] ox, oy, oz,
         dx, dy, dz, lx, ly, lz, hx, hy, hz);
      req_payload_type p;
      p = {ox, oy, oz, dx, dy, dz, lx, ly, lz, hx, hy, hz};
      return p;
   endfunction

   localparam logic [31:0] ONE = 32'h0001_0000;
   localparam logic [31:0] MAXC = 32'h7FFF_FFFF;
   localparam logic [31:0] MINC = 32'h8000_0000;

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      sb.thresh = THRESH_RESET;
      set_threshold(17'd1);

      // Directed words: zero direction, parallel, inside, touching, extremes
      send_word(make_ray(0, 0, 0, 0, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      send_word(make_ray(0, 0, 0, ONE, 0, 0, -ONE, -ONE, -ONE, ONE, ONE, ONE));
      send_word(make_ray(-5*ONE, 0, 0, ONE, 0, 0, ONE, -ONE, -ONE, 2*ONE, ONE, ONE));
      send_word(make_ray(-5*ONE, 3*ONE, 0, ONE, 0, 0, ONE, -ONE, -ONE, 2*ONE, ONE, ONE));
      send_word(make_ray(-5*ONE, 0, 0, ONE, 0, 0, 2*ONE, 0, 0, ONE, 0, 0));
      send_word(make_ray(0, 0, 0, ONE, ONE, 0, ONE, 2*ONE, 0, ONE, 3*ONE, 0));
      send_word(make_ray(0, 0, 0, ONE, ONE, 0, ONE, ONE, 0, 2*ONE, 2*ONE, 0));
      send_word(make_ray(MINC, 0, 0, 1, 0, 0, MAXC, MINC, MINC, MAXC, MAXC, MAXC));
      send_word(make_ray(MAXC, MAXC, MAXC, MINC, MINC, MINC,
                         MINC, MINC, MINC, MINC, MINC, MINC));
      send_word(make_ray(0, 0, 0, MINC, MAXC, 1, MINC, MINC, MINC, MAXC, MAXC, MAXC));
      send_word(make_ray(0, 0, 0, -ONE, 0, 0, -3*ONE, -ONE, -ONE, -2*ONE, ONE, ONE));
      send_word(make_ray(0, 0, 0, ONE, 0, 0, ONE, MAXC, 0, 2*ONE, MINC, 0));
      send_word(make_ray(0, 0, 0, 3, 7, -9, 5, 5, -5, 100, 100, -100));
      set_threshold(17'h10000);
      send_word(make_ray(0, 0, 0, 32'hFFFF, ONE, 0, -1, ONE, 0, 1, 2*ONE, 0));
      send_word(make_ray(0, 0, 0, ONE, 2, 0, ONE, 0, 0, 2*ONE, 0, 0));
      set_threshold(17'd0);
      send_word(make_ray(0, 0, 0, 1, 0, 0, ONE, 0, 0, 2*ONE, 0, 0));
      send_word(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

      // Random phases over idling patterns and thresholds
      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle = 0;  recv_stall = 0;  end
            1: begin send_idle = 73; recv_stall = 0;  end
            2: begin send_idle = 0;  recv_stall = 73; end
            default: begin send_idle = 20; recv_stall = 20; end
         endcase
         case (ph)
            0: set_threshold(17'd1);
            1: set_threshold(17'h1FFFF);
            2: set_threshold(17'd0);
            3: set_threshold(17'h10000);
            default: set_threshold(17'($urandom_range(131071)));
         endcase
         for (int i = 0; i < 70; i++) send_word(rand_ray());
      end

      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

// ----- ray_box_slab_intersect.f -----
+incdir+rtl/core
rtl/core/rbs_pkg.sv
rtl/core/ray_box_slab_intersect.sv
rtl/core/rbs_checker.sv
dv/tb_top.sv
